[rtl/light_charge_meter_display_top_assert.svh]
// Assertion macros for the charge meter top level.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef LIGHT_CHARGE_METER_DISPLAY_TOP_ASSERT_SVH
`define LIGHT_CHARGE_METER_DISPLAY_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LCMD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lcmd assertion failed");

// Next-cycle implication, disabled during reset.
`define LCMD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lcmd assertion failed");

`endif

[rtl/lcmd_pkg.sv]
`timescale 1ns / 1ps

package lcmd_pkg;

  localparam int unsigned LevelW   = 10;
  localparam int unsigned SegW     = 8;
  localparam int unsigned NumLeds  = 8;

  localparam logic [LevelW-1:0] LevelMax       = 10'd1000;
  localparam logic [LevelW-1:0] LevelStep      = 10'd4;
  localparam logic [LevelW-1:0] ThresholdReset = 10'd871;
  localparam int unsigned       LevelPerLed    = 125;
  localparam logic [SegW-1:0]   SegDp          = 8'h80;

  // Display fields that leave the decoder together.
  typedef struct packed {
    logic [NumLeds-1:0] bar;
    logic [SegW-1:0]    seg_tenths;
    logic [SegW-1:0]    seg_ones;
    logic [SegW-1:0]    seg_tens;
    logic [SegW-1:0]    seg_hundreds;
  } disp_t;

  // Seven-segment code for one decimal digit, segments a..g on bits 0..6.
  function automatic logic [SegW-1:0] seg_code(input logic [3:0] digit);
    logic [SegW-1:0] code;
    case (digit)
      4'd0:    code = 8'h3f;
      4'd1:    code = 8'h06;
      4'd2:    code = 8'h5b;
      4'd3:    code = 8'h4f;
      4'd4:    code = 8'h66;
      4'd5:    code = 8'h6d;
      4'd6:    code = 8'h7c;
      4'd7:    code = 8'h07;
      4'd8:    code = 8'h7f;
      4'd9:    code = 8'h67;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

  // Bar graph: dark at zero, otherwise level/125 + 1 LEDs, capped at all eight.
  function automatic logic [NumLeds-1:0] bar_of(input logic [LevelW-1:0] level);
    logic [3:0] cnt;
    logic [NumLeds:0] mask;
    cnt = 4'd1;
    for (int k = 1; k < NumLeds; k++) begin
      if (level >= LevelW'(k * LevelPerLed)) begin
        cnt = cnt + 4'd1;
      end
    end
    mask = (9'd1 << cnt) - 9'd1;
    if (level == '0) begin
      mask = '0;
    end
    return mask[NumLeds-1:0];
  endfunction

endpackage

[rtl/lcmd_decode.sv]
`timescale 1ns / 1ps

// Splits the level into decimal digits and builds the LED and segment codes.
module lcmd_decode (
  input  logic [9:0]     level_i,
  output lcmd_pkg::disp_t disp_o
);

  // Reciprocal constants, exact over the full 10-bit input range.
  localparam logic [17:0] Recip10  = 18'd205;
  localparam logic [15:0] Recip100 = 16'd41;

  logic [17:0] prod10;
  logic [15:0] prod100;
  logic [6:0]  quot10;
  logic [3:0]  quot100;
  logic [9:0]  ones_w;
  logic [6:0]  tens_w;
  logic        thou;
  logic [3:0]  d_units;
  logic [3:0]  d_tens;
  logic [3:0]  d_hund;
  logic [3:0]  d_thou;

  // Divide by ten and by one hundred in parallel.
  assign prod10  = {8'b0, level_i} * Recip10;
  assign prod100 = {6'b0, level_i} * Recip100;
  assign quot10  = prod10[17:11];
  assign quot100 = prod100[15:12];

  // Remainders by subtracting the scaled quotient.
  assign ones_w  = level_i - ({quot10, 3'b000} + {2'b00, quot10, 1'b0});
  assign tens_w  = quot10 - ({quot100, 3'b000} + {2'b00, quot100, 1'b0});
  assign thou    = (quot100 >= 4'd10);

  assign d_units = ones_w[3:0];
  assign d_tens  = tens_w[3:0];
  assign d_hund  = quot100 - (thou ? 4'd10 : 4'd0);
  assign d_thou  = {3'b000, thou};

  // Display codes; the tens digit carries the decimal point.
  always_comb begin
    disp_o.bar          = lcmd_pkg::bar_of(level_i);
    disp_o.seg_tenths   = lcmd_pkg::seg_code(d_units);
    disp_o.seg_ones     = lcmd_pkg::seg_code(d_tens) | lcmd_pkg::SegDp;
    disp_o.seg_tens     = lcmd_pkg::seg_code(d_hund);
    disp_o.seg_hundreds = lcmd_pkg::seg_code(d_thou);
  end

endmodule

[rtl/light_charge_meter_display_top.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// -------   ---------  --------------------  --------------------------------------
// in        input      in_valid_i/in_stall_o light_sample_i
// out       output     out_valid_o/out_stall_i bar_leds_o, seg_*_o, charge_level_o
// cfg       input      cfg_valid_i/cfg_ready_o cfg_data_i (light_threshold)
//
// One sample is accepted per cycle unless in_stall_o is high; its result passes through
// the level register and then the output register. The charge update (one add and compare)
// happens at acceptance; the digit split and segment coding sit between those registers.
// Reset clears the charge to zero and loads the threshold with 871.
// A stalled output holds its transaction; the input stalls only when the level stage is
// full and the output register is full and stalled.
module light_charge_meter_display_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [9:0] light_sample_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] bar_leds_o,
  output logic [7:0] seg_tenths_o,
  output logic [7:0] seg_ones_o,
  output logic [7:0] seg_tens_o,
  output logic [7:0] seg_hundreds_o,
  output logic [9:0] charge_level_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [9:0] cfg_data_i
);

  logic [9:0]      thresh_q;
  logic [9:0]      charge_q, charge_d;
  logic            lvl_valid_q;
  logic            out_valid_q;
  logic            lvl_adv;
  logic            in_accept;
  logic [10:0]     up_sum;
  lcmd_pkg::disp_t disp;
  lcmd_pkg::disp_t disp_q;
  logic [9:0]      level_out_q;

  // The threshold register takes every write.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= lcmd_pkg::ThresholdReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      thresh_q <= cfg_data_i;
    end
  end

  // Handshake: the level stage moves on when the output register is free or taken.
  assign lvl_adv    = !out_valid_q || !out_stall_i;
  assign in_stall_o = lvl_valid_q && !lvl_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Saturating charge step.
  assign up_sum = {1'b0, charge_q} + {1'b0, lcmd_pkg::LevelStep};

  always_comb begin
    if (light_sample_i >= thresh_q) begin
      charge_d = (up_sum > {1'b0, lcmd_pkg::LevelMax}) ? lcmd_pkg::LevelMax : up_sum[9:0];
    end else begin
      charge_d = (charge_q < lcmd_pkg::LevelStep) ? '0 : charge_q - lcmd_pkg::LevelStep;
    end
  end

  // The charge register doubles as the level stage payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      charge_q    <= '0;
      lvl_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        charge_q <= charge_d;
      end
      if (in_accept) begin
        lvl_valid_q <= 1'b1;
      end else if (lvl_adv) begin
        lvl_valid_q <= 1'b0;
      end
    end
  end

  lcmd_decode u_decode (
    .level_i (charge_q),
    .disp_o  (disp)
  );

  // Output register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (lvl_adv) begin
      out_valid_q <= lvl_valid_q;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (lvl_adv && lvl_valid_q) begin
      disp_q      <= disp;
      level_out_q <= charge_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign bar_leds_o     = disp_q.bar;
  assign seg_tenths_o   = disp_q.seg_tenths;
  assign seg_ones_o     = disp_q.seg_ones;
  assign seg_tens_o     = disp_q.seg_tens;
  assign seg_hundreds_o = disp_q.seg_hundreds;
  assign charge_level_o = level_out_q;

  `include "light_charge_meter_display_top_assert.svh"

  // The level never leaves its range.
  `LCMD_ASSERT_IMP(a_level_range, 1'b1, charge_q <= lcmd_pkg::LevelMax)

  // The charge moves only when a transaction is accepted.
  `LCMD_ASSERT_NXT(a_charge_hold, !in_accept, charge_q == $past(charge_q))

  // An accepted transaction always fills the level stage.
  `LCMD_ASSERT_NXT(a_accept_fills, in_accept, lvl_valid_q)

  // A delivered zero level shows a dark bar.
  `LCMD_ASSERT_IMP(a_bar_dark, out_valid_o && (charge_level_o == '0), bar_leds_o == '0)

endmodule

[sim/light_charge_meter_display_top_tb.sv]
`timescale 1ns / 1ps

module light_charge_meter_display_top_tb;

  // One displayed reading, field for field as the output ports carry it.
  typedef struct packed {
    logic [7:0] bar_leds;
    logic [7:0] seg_tenths;
    logic [7:0] seg_ones;
    logic [7:0] seg_tens;
    logic [7:0] seg_hundreds;
    logic [9:0] charge_level;
  } meter_reading_t;

  typedef enum logic {ROW_SAMPLE, ROW_THRESHOLD} row_kind_e;

  // A directed step: either a sample or a threshold write, optionally with a pinned reading.
  typedef struct packed {
    row_kind_e      kind;
    logic [9:0]     value;
    logic           pinned;
    meter_reading_t reading;
  } stim_row_t;

  localparam meter_reading_t ReadingZero  = '{8'h00, 8'h3f, 8'hbf, 8'h3f, 8'h3f, 10'd0};
  localparam meter_reading_t ReadingFour  = '{8'h01, 8'h66, 8'hbf, 8'h3f, 8'h3f, 10'd4};
  localparam meter_reading_t ReadingEight = '{8'h01, 8'h7f, 8'hbf, 8'h3f, 8'h3f, 10'd8};

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [9:0] light_sample_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] bar_leds_o;
  logic [7:0] seg_tenths_o;
  logic [7:0] seg_ones_o;
  logic [7:0] seg_tens_o;
  logic [7:0] seg_hundreds_o;
  logic [9:0] charge_level_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [9:0] cfg_data_i = '0;

  // Segment patterns for digits 0 to 9, segments a..g on bits 0..6.
  logic [7:0] digit_font [0:9] = '{8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66,
                                   8'h6d, 8'h7c, 8'h07, 8'h7f, 8'h67};

  // Shadow state of the meter and the queue of readings still to come out.
  int             charge_model = 0;
  logic [9:0]     threshold_model = lcmd_pkg::ThresholdReset;
  meter_reading_t pending_readings [$];
  meter_reading_t seen_reading;
  meter_reading_t next_reading;
  int             fail_count = 0;

  // Pinned reading for the sample currently offered, set by the driver.
  logic           pin_valid = 1'b0;
  meter_reading_t pin_reading = '0;

  // Idle control for both channels.
  bit gaps_on = 1'b1;
  int stall_pct = 0;
  int stall_epoch = 0;
  int stall_burst = 0;

  stim_row_t directed_rows [22];

  light_charge_meter_display_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .light_sample_i (light_sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .bar_leds_o     (bar_leds_o),
    .seg_tenths_o   (seg_tenths_o),
    .seg_ones_o     (seg_ones_o),
    .seg_tens_o     (seg_tens_o),
    .seg_hundreds_o (seg_hundreds_o),
    .charge_level_o (charge_level_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Step the charge by one sample and work out the display it produces.
  function automatic meter_reading_t advance_meter(input logic [9:0] sample);
    meter_reading_t r;
    int leds;
    if (sample >= threshold_model) begin
      charge_model = charge_model + int'(lcmd_pkg::LevelStep);
      if (charge_model > int'(lcmd_pkg::LevelMax)) begin
        charge_model = int'(lcmd_pkg::LevelMax);
      end
    end else begin
      charge_model = (charge_model < int'(lcmd_pkg::LevelStep)) ?
                     0 : charge_model - int'(lcmd_pkg::LevelStep);
    end
    leds = charge_model / int'(lcmd_pkg::LevelPerLed) + 1;
    if (leds > 8) begin
      leds = 8;
    end
    r.bar_leds     = (charge_model == 0) ? 8'h00 : 8'((9'd1 << leds) - 9'd1);
    r.seg_tenths   = digit_font[charge_model % 10];
    r.seg_ones     = digit_font[(charge_model / 10) % 10] | lcmd_pkg::SegDp;
    r.seg_tens     = digit_font[(charge_model / 100) % 10];
    r.seg_hundreds = digit_font[(charge_model / 1000) % 10];
    r.charge_level = 10'(charge_model);
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Sample accepted transactions on all three channels at the rising edge.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      charge_model = 0;
      threshold_model = lcmd_pkg::ThresholdReset;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_readings.size() == 0) begin
          $error("charge_level: no reading expected, actual 0x%0h", charge_level_o);
          fail_count++;
        end else begin
          seen_reading = pending_readings.pop_front();
          check_field("bar_leds", seen_reading.bar_leds, bar_leds_o);
          check_field("seg_tenths", seen_reading.seg_tenths, seg_tenths_o);
          check_field("seg_ones", seen_reading.seg_ones, seg_ones_o);
          check_field("seg_tens", seen_reading.seg_tens, seg_tens_o);
          check_field("seg_hundreds", seen_reading.seg_hundreds, seg_hundreds_o);
          check_field("charge_level", seen_reading.charge_level, charge_level_o);
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        threshold_model = cfg_data_i;
      end
      if (in_valid_i && !in_stall_o) begin
        next_reading = advance_meter(light_sample_i);
        pending_readings.push_back(pin_valid ? pin_reading : next_reading);
      end
    end
  end

  // Output stall: bursts mostly short, some long, with the stall rate changing over time.
  always @(negedge clk_i) begin
    if (stall_epoch == 0) begin
      stall_epoch = 300;
      case ($urandom_range(0, 3))
        0:       stall_pct = 0;
        1:       stall_pct = 15;
        2:       stall_pct = 35;
        default: stall_pct = 60;
      endcase
    end else begin
      stall_epoch--;
    end
    if (stall_burst == 0) begin
      out_stall_i <= rst_ni && ($urandom_range(0, 99) < stall_pct);
      stall_burst = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
    end
    stall_burst--;
  end

  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) begin
      return 0;
    end
    return (r < 92) ? $urandom_range(1, 3) : $urandom_range(5, 30);
  endfunction

  // Offer one sample and hold it until the block takes it.
  task automatic send_sample(input logic [9:0] sample, input logic pinned,
                             input meter_reading_t reading);
    int gap;
    @(negedge clk_i);
    pin_valid = pinned;
    pin_reading = reading;
    in_valid_i <= 1'b1;
    light_sample_i <= sample;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    gap = idle_cycles();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      light_sample_i <= 10'($urandom_range(0, 1023));
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Let every reading drain, then write the threshold while the block is idle.
  task automatic set_threshold(input logic [9:0] value);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_readings.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [9:0] pick_sample(input logic [9:0] thr, input int rise_pct);
    if (thr == 0 || $urandom_range(0, 99) < rise_pct) begin
      return 10'($urandom_range(1023, thr));
    end
    return 10'($urandom_range(thr - 1, 0));
  endfunction

  initial begin
    logic [9:0] thr;
    int rise_pct;
    int count;

    // Directed steps: the lower saturation end near zero, threshold extremes and edges.
    directed_rows = '{
      '{ROW_SAMPLE,    10'd0,    1'b1, ReadingZero},
      '{ROW_SAMPLE,    10'd870,  1'b1, ReadingZero},
      '{ROW_SAMPLE,    10'd871,  1'b1, ReadingFour},
      '{ROW_SAMPLE,    10'd1023, 1'b1, ReadingEight},
      '{ROW_SAMPLE,    10'd870,  1'b1, ReadingFour},
      '{ROW_SAMPLE,    10'd869,  1'b1, ReadingZero},
      '{ROW_SAMPLE,    10'd0,    1'b1, ReadingZero},
      '{ROW_THRESHOLD, 10'd0,    1'b0, '0},
      '{ROW_SAMPLE,    10'd0,    1'b0, '0},
      '{ROW_SAMPLE,    10'h155,  1'b0, '0},
      '{ROW_SAMPLE,    10'h2aa,  1'b0, '0},
      '{ROW_SAMPLE,    10'h3ff,  1'b0, '0},
      '{ROW_THRESHOLD, 10'd1023, 1'b0, '0},
      '{ROW_SAMPLE,    10'd1022, 1'b0, '0},
      '{ROW_SAMPLE,    10'd1023, 1'b0, '0},
      '{ROW_SAMPLE,    10'd1021, 1'b0, '0},
      '{ROW_THRESHOLD, 10'd512,  1'b0, '0},
      '{ROW_SAMPLE,    10'd511,  1'b0, '0},
      '{ROW_SAMPLE,    10'd512,  1'b0, '0},
      '{ROW_SAMPLE,    10'd513,  1'b0, '0},
      '{ROW_THRESHOLD, 10'd871,  1'b0, '0},
      '{ROW_SAMPLE,    10'd1,    1'b0, '0}
    };

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_THRESHOLD) begin
        set_threshold(directed_rows[i].value);
      end else begin
        send_sample(directed_rows[i].value, directed_rows[i].pinned, directed_rows[i].reading);
      end
    end

    // Random phases: a full climb to the top, a full fall to the bottom, then mixed drift.
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: begin
          thr = 10'd0;
          rise_pct = 100;
          count = 300;
        end
        1: begin
          thr = 10'd1023;
          rise_pct = 0;
          count = 300;
        end
        default: begin
          case ($urandom_range(0, 5))
            0:       thr = 10'd0;
            1:       thr = 10'd1023;
            2:       thr = lcmd_pkg::ThresholdReset;
            default: thr = 10'($urandom_range(1, 1022));
          endcase
          rise_pct = ($urandom_range(0, 2) == 0) ? $urandom_range(15, 85) : $urandom_range(40, 60);
          count = 125;
        end
      endcase
      gaps_on = (ph % 3 != 2);
      set_threshold(thr);
      repeat (count) send_sample(pick_sample(thr, rise_pct), 1'b0, '0);
    end

    // Drain and let any stray result show up before the verdict.
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_readings.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/lcmd_pkg.sv
rtl/lcmd_decode.sv
rtl/light_charge_meter_display_top.sv
sim/light_charge_meter_display_top_tb.sv
